// ===== hdl/psa_pkg.sv =====
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types, constants and tables for the pixel saturation adjust block.
// ----------------------------------------------------------------------------
package psa_pkg;

	localparam int PIX_W       = 8;
	localparam int GAIN_W      = 11;
	localparam int ROOT_W      = 16;
	localparam int NUM_GAINS   = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int STAGES      = 16;
	localparam int SQRT_STAGES = 4;
	localparam int RECIP_W     = 25;
	localparam int RECIP_SHIFT = 24;

	localparam logic [GAIN_W-1:0] GAIN_ONE = 11'd256;

	// floor(n / 255) = (n * DIV255_M) >> 24 for n <= 255 * 255
	localparam logic [16:0] DIV255_M = 17'd65794;

	// sqrt(0.299), sqrt(0.587), sqrt(0.114) in Q0.16, and their complements
	localparam logic [15:0] SQRT_W [3] = '{16'd35836, 16'd50211, 16'd22127};
	localparam logic [15:0] SQRT_WC [3] = '{
		16'(65536 - 35836), 16'(65536 - 50211), 16'(65536 - 22127)
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_ALL,
		REG_GAIN_RED,
		REG_GAIN_GREEN,
		REG_GAIN_BLUE
	} psa_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] r;
		logic [PIX_W-1:0] g;
		logic [PIX_W-1:0] b;
		logic [PIX_W-1:0] a;
	} psa_rgba_t;

	typedef struct packed {
		logic [ROOT_W+1:0] rem;
		logic [ROOT_W-1:0] root;
	} psa_sqrt_t;

	typedef struct packed {
		logic [SQRT_STAGES-1:0] adv;
	} psa_sqrt_ctl_t;

	typedef logic [255:0][RECIP_W-1:0] recip_tab_t;

	// ceil(2^24 / a) by long division; entry 0 is never used
	function automatic recip_tab_t build_recip();
		recip_tab_t         t;
		logic [RECIP_W-1:0] num;
		logic [RECIP_W-1:0] den;
		logic [RECIP_W-1:0] quo;
		logic [RECIP_W:0]   rem;
		t = '0;
		for (int i = 1; i < 256; i++) begin
			num = RECIP_W'((1 << RECIP_SHIFT) + i - 1);
			den = RECIP_W'(i);
			quo = '0;
			rem = '0;
			for (int b = RECIP_W-1; b >= 0; b--) begin
				rem = {rem[RECIP_W-1:0], num[b]};
				if (rem >= {1'b0, den}) begin
					rem    = rem - {1'b0, den};
					quo[b] = 1'b1;
				end
			end
			t[i] = quo;
		end
		return t;
	endfunction

	localparam recip_tab_t RECIP_TAB = build_recip();

	// one restoring root digit
	function automatic psa_sqrt_t sqrt_step(psa_sqrt_t s, logic [1:0] pair);
		logic [ROOT_W+3:0] acc;
		logic [ROOT_W+3:0] trial;
		psa_sqrt_t r;
		acc   = {s.rem, pair};
		trial = {2'b00, s.root, 2'b01};
		if (acc >= trial) begin
			r.rem  = (ROOT_W+2)'(acc - trial);
			r.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = acc[ROOT_W+1:0];
			r.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic psa_sqrt_t sqrt_4steps(psa_sqrt_t s, logic [7:0] bits);
		psa_sqrt_t r;
		r = s;
		for (int i = 3; i >= 0; i--) begin
			r = sqrt_step(r, bits[2*i +: 2]);
		end
		return r;
	endfunction

endpackage

// ===== hdl/psa_sqrt.sv =====
// ----------------------------------------------------------------------------
// psa_sqrt
// Four-stage integer square root of (rad << 16), four digits per stage.
// ----------------------------------------------------------------------------
module psa_sqrt (
	input  logic                          clk,
	input  psa_pkg::psa_sqrt_ctl_t        ctl,
	input  logic [psa_pkg::ROOT_W-1:0]    rad,
	output logic [psa_pkg::ROOT_W-1:0]    root
);
	import psa_pkg::*;

	psa_sqrt_t  st_s1, st_s2, st_s3, st_s4;
	logic [7:0] lo_s1;

	always_ff @(posedge clk) begin
		if (ctl.adv[0]) begin
			st_s1 <= sqrt_4steps('0, rad[15:8]);
			lo_s1 <= rad[7:0];
		end
		if (ctl.adv[1]) begin
			st_s2 <= sqrt_4steps(st_s1, lo_s1);
		end
		if (ctl.adv[2]) begin
			st_s3 <= sqrt_4steps(st_s2, 8'h00);
		end
		if (ctl.adv[3]) begin
			st_s4 <= sqrt_4steps(st_s3, 8'h00);
		end
	end

	assign root = st_s4.root;

endmodule

// ===== hdl/pixel_saturation_adjust.sv =====
// ----------------------------------------------------------------------------
// pixel_saturation_adjust
// Saturation adjust of premultiplied RGBA pixels, sixteen-stage pipeline.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  pixel    | pix_valid / pix_stall | red_in, green_in, blue_in, alpha_in
//  result   | res_valid / res_stall | red_out, green_out, blue_out, alpha_out
//  config   | cfg_we                | cfg_index, cfg_data
//
//  One pixel per cycle unless pix_stall is raised; stage counts: un-premultiply
//  (2), brightness (2), root (4), common gain (2), channel mix (4), premultiply (2).
//  Reset clears all valid bits and loads every gain with 1.0.
//  Each stage advances when empty or when the next one advances, so bubbles
//  collapse; pix_stall rises only with all sixteen stages full under res_stall.
// ----------------------------------------------------------------------------
module pixel_saturation_adjust (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	output logic                             pix_stall,
	input  logic [psa_pkg::PIX_W-1:0]        red_in,
	input  logic [psa_pkg::PIX_W-1:0]        green_in,
	input  logic [psa_pkg::PIX_W-1:0]        blue_in,
	input  logic [psa_pkg::PIX_W-1:0]        alpha_in,
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic [psa_pkg::PIX_W-1:0]        red_out,
	output logic [psa_pkg::PIX_W-1:0]        green_out,
	output logic [psa_pkg::PIX_W-1:0]        blue_out,
	output logic [psa_pkg::PIX_W-1:0]        alpha_out,
	input  logic                             cfg_we,
	input  logic [psa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [psa_pkg::GAIN_W-1:0]       cfg_data
);
	import psa_pkg::*;

	logic [GAIN_W-1:0] gain_q [NUM_GAINS];
	logic [GAIN_W-1:0] gch [3];

	logic [STAGES:1]   vld_q;
	logic [STAGES+1:1] adv;

	psa_rgba_t          raw_s [1:STAGES-1];
	logic [RECIP_W-1:0] recip_s1;
	logic [7:0]         u_s [2:8][3];
	logic [15:0]        sq_s3 [3];
	logic [15:0]        w_s4;
	logic [ROOT_W-1:0]  root_s8;
	logic [ROOT_W-1:0]  p_s9;
	logic signed [29:0] cgp_s9 [3];
	logic [7:0]         cg_s10 [3];
	logic [23:0]        q_s11 [3];
	logic [23:0]        k_s11 [3];
	logic [34:0]        op_s12 [3];
	logic signed [35:0] cp_s12 [3];
	logic [23:0]        qc_s12 [3];
	logic [10:0]        own_s13 [3];
	logic signed [11:0] cross_s13 [3];
	logic [7:0]         mix_s14 [3];
	logic [15:0]        pm_s15 [3];
	psa_rgba_t          res_s16;

	logic [7:0]         ch1 [3];
	logic [15:0]        un_num [3];
	logic [40:0]        un_prod [3];
	logic [24:0]        wsum;
	logic signed [17:0] cg_diff [3];
	logic signed [29:0] cg_mul [3];
	logic signed [30:0] cg_num [3];
	logic signed [11:0] gdiff [3];
	logic [34:0]        own_num [3];
	logic [35:0]        cmag [3];
	logic signed [13:0] mix_sum [3];
	logic [32:0]        dv_prod [3];

	psa_sqrt_ctl_t      sqrt_ctl;

	assign gch[0] = gain_q[REG_GAIN_RED];
	assign gch[1] = gain_q[REG_GAIN_GREEN];
	assign gch[2] = gain_q[REG_GAIN_BLUE];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_GAINS; i++) begin
				gain_q[i] <= GAIN_ONE;
			end
		end else if (cfg_we) begin
			gain_q[cfg_index] <= cfg_data;
		end
	end

	// flow control
	always_comb begin
		adv[STAGES+1] = !res_stall;
		for (int k = STAGES; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign pix_stall = !adv[1];
	assign res_valid = vld_q[STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= pix_valid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// raw pixel travels alongside for alpha and the transparent bypass
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			raw_s[1] <= '{r: red_in, g: green_in, b: blue_in, a: alpha_in};
			recip_s1 <= RECIP_TAB[alpha_in];
		end
		for (int k = 2; k <= STAGES-1; k++) begin
			if (adv[k]) begin
				raw_s[k] <= raw_s[k-1];
			end
		end
	end

	// s2: un-premultiply, c * 255 / a by reciprocal
	assign ch1[0] = raw_s[1].r;
	assign ch1[1] = raw_s[1].g;
	assign ch1[2] = raw_s[1].b;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			un_num[j]  = {ch1[j], 8'h00} - 16'(ch1[j]);
			un_prod[j] = 41'(un_num[j]) * 41'(recip_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int j = 0; j < 3; j++) begin
				u_s[2][j] <= (ch1[j] >= raw_s[1].a) ? 8'hFF : un_prod[j][31:24];
			end
		end
		for (int k = 3; k <= 8; k++) begin
			if (adv[k]) begin
				u_s[k] <= u_s[k-1];
			end
		end
	end

	// s3, s4: brightness radicand
	assign wsum = 25'(sq_s3[0]) * 25'(77) + 25'(sq_s3[1]) * 25'(150)
		+ 25'(sq_s3[2]) * 25'(29) + 25'(128);

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int j = 0; j < 3; j++) begin
				sq_s3[j] <= 16'(u_s[2][j]) * 16'(u_s[2][j]);
			end
		end
		if (adv[4]) begin
			w_s4 <= wsum[23:8];
		end
	end

	// s5..s8: brightness root, 8.8
	assign sqrt_ctl.adv = adv[8:5];

	psa_sqrt u_sqrt (
		.clk  (clk),
		.ctl  (sqrt_ctl),
		.rad  (w_s4),
		.root (root_s8)
	);

	// s9, s10: common gain
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			cg_diff[j] = $signed({2'b00, u_s[8][j], 8'h00}) - $signed({2'b00, root_s8});
			cg_mul[j]  = 30'(cg_diff[j]) * 30'($signed({1'b0, gain_q[REG_GAIN_ALL]}));
			cg_num[j]  = $signed({7'd0, p_s9, 8'h00}) + 31'(cgp_s9[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			p_s9 <= root_s8;
			for (int j = 0; j < 3; j++) begin
				cgp_s9[j] <= cg_mul[j];
			end
		end
		if (adv[10]) begin
			for (int j = 0; j < 3; j++) begin
				if (cg_num[j][30]) begin
					cg_s10[j] <= 8'h00;
				end else if (|cg_num[j][29:24]) begin
					cg_s10[j] <= 8'hFF;
				end else begin
					cg_s10[j] <= cg_num[j][23:16];
				end
			end
		end
	end

	// s11..s14: channel mix
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			gdiff[j]   = $signed(12'(GAIN_ONE)) - $signed({1'b0, gch[j]});
			own_num[j] = {3'b000, qc_s12[j], 8'h00} + op_s12[j];
			cmag[j]    = cp_s12[j][35] ? 36'(-cp_s12[j]) : 36'(cp_s12[j]);
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mix_sum[j] = $signed({3'b000, own_s13[j]});
			for (int i = 0; i < 3; i++) begin
				if (i != j) begin
					mix_sum[j] = mix_sum[j] + 14'(cross_s13[i]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[11]) begin
			for (int j = 0; j < 3; j++) begin
				q_s11[j] <= 24'(cg_s10[j]) * 24'(SQRT_W[j]);
				k_s11[j] <= 24'(cg_s10[j]) * 24'(SQRT_WC[j]);
			end
		end
		if (adv[12]) begin
			for (int j = 0; j < 3; j++) begin
				op_s12[j] <= 35'(k_s11[j]) * 35'(gch[j]);
				cp_s12[j] <= 36'($signed({1'b0, q_s11[j]})) * 36'(gdiff[j]);
				qc_s12[j] <= q_s11[j];
			end
		end
		if (adv[13]) begin
			for (int j = 0; j < 3; j++) begin
				own_s13[j] <= own_num[j][34:24];
				if (cp_s12[j][35]) begin
					cross_s13[j] <= -$signed({1'b0, cmag[j][34:24]});
				end else begin
					cross_s13[j] <= $signed({1'b0, cmag[j][34:24]});
				end
			end
		end
		if (adv[14]) begin
			for (int j = 0; j < 3; j++) begin
				if (mix_sum[j][13]) begin
					mix_s14[j] <= 8'h00;
				end else if (|mix_sum[j][12:8]) begin
					mix_s14[j] <= 8'hFF;
				end else begin
					mix_s14[j] <= mix_sum[j][7:0];
				end
			end
		end
	end

	// s15, s16: premultiply, c * a / 255 by reciprocal
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			dv_prod[j] = 33'(pm_s15[j]) * 33'(DIV255_M);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[15]) begin
			for (int j = 0; j < 3; j++) begin
				pm_s15[j] <= 16'(mix_s14[j]) * 16'(raw_s[14].a);
			end
		end
		if (adv[16]) begin
			res_s16.a <= raw_s[15].a;
			if (raw_s[15].a == '0) begin
				res_s16.r <= raw_s[15].r;
				res_s16.g <= raw_s[15].g;
				res_s16.b <= raw_s[15].b;
			end else begin
				res_s16.r <= dv_prod[0][31:24];
				res_s16.g <= dv_prod[1][31:24];
				res_s16.b <= dv_prod[2][31:24];
			end
		end
	end

	assign red_out   = res_s16.r;
	assign green_out = res_s16.g;
	assign blue_out  = res_s16.b;
	assign alpha_out = res_s16.a;

endmodule

// ===== hdl/psa_checker.sv =====
// ----------------------------------------------------------------------------
// psa_checker
// Port-level checks for pixel_saturation_adjust, bound to the top level.
// ----------------------------------------------------------------------------
module psa_port_checks (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      pix_stall,
	input logic                      res_valid,
	input logic                      res_stall,
	input logic [psa_pkg::PIX_W-1:0] red_out,
	input logic [psa_pkg::PIX_W-1:0] green_out,
	input logic [psa_pkg::PIX_W-1:0] blue_out,
	input logic [psa_pkg::PIX_W-1:0] alpha_out
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(red_out) && $stable(green_out)
			&& $stable(blue_out) && $stable(alpha_out))
		else $error("stalled result changed");

	// with the last stage free, the pipeline takes a pixel
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!res_valid || !res_stall) |-> !pix_stall)
		else $error("pixel stalled while pipeline can advance");

	// premultiplied colour never exceeds a nonzero alpha
	a_premul_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && alpha_out != '0 |-> red_out <= alpha_out
			&& green_out <= alpha_out && blue_out <= alpha_out)
		else $error("colour above alpha on result");

	// no result straight out of reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !res_valid)
		else $error("result valid after reset");

endmodule

bind pixel_saturation_adjust psa_port_checks u_psa_port_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_stall (pix_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.red_out   (red_out),
	.green_out (green_out),
	.blue_out  (blue_out),
	.alpha_out (alpha_out)
);
